>>> rtl/pcorr_pkg.sv
// Shared types and constants for the pulse template correlator.
// Item, command and result structs, operation and register codes.
// No dependencies; imported by the front, back and top modules.
package pcorr_pkg;

    localparam int SAMPLE_W    = 16;   // Q1.15 sample
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int SUM_W       = 48;   // Q18.30 accumulator
    localparam int POS_W       = 12;   // load address and pulse positions
    localparam int TLEN_W      = 11;
    localparam int BLEN_W      = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 1;
    // Run length and counters; wide enough for the full depth parameter range.
    localparam int LEN_W       = 21;

    localparam int DEF_TEMPLATE_DEPTH = 1024;
    localparam int DEF_BLOCK_DEPTH    = 4096;
    localparam int TLEN_RESET         = 1024;
    localparam int BLEN_RESET         = 4096;
    localparam int QUEUE_DEPTH        = 2;

    typedef enum logic [1:0] {
        OP_LOAD_TEMPLATE = 2'd0,
        OP_LOAD_DATA     = 2'd1,
        OP_PHI           = 2'd2,
        OP_LAMBDA        = 2'd3
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TEMPLATE_LENGTH = 1'b0,
        REG_BLOCK_LENGTH    = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        KIND_PHI    = 1'b0,
        KIND_LAMBDA = 1'b1
    } kind_t;

    typedef struct packed {
        op_t                        operation;
        logic [POS_W-1:0]           load_address;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [POS_W-1:0]           position_a;
        logic [POS_W-1:0]           position_b;
    } item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum_value;
        kind_t                   result_kind;
    } result_t;

    // Classified command handed from front to back.
    typedef struct packed {
        op_t                        op;
        logic [POS_W-1:0]           addr;
        logic signed [SAMPLE_W-1:0] sample;
        logic [LEN_W-1:0]           len;     // products to accumulate
        logic [POS_W-1:0]           offset;  // start of second operand
    } cmd_t;

endpackage

>>> rtl/pcorr_fifo.sv
// Small register queue, generic over the entry type.
// Depends on nothing; used for the command queue and the result queue.
module pcorr_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     data_in,
    output logic full,
    input  logic pop,
    output T     data_out,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    T                 mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= data_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/pcorr_front.sv
// Front end: length registers, item intake and classification into commands.
// Works out run length and second-operand offset for each query.
// Depends on pcorr_pkg.
module pcorr_front import pcorr_pkg::*; #(
    parameter int TEMPLATE_DEPTH = DEF_TEMPLATE_DEPTH,
    parameter int BLOCK_DEPTH    = DEF_BLOCK_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   push,
    input  item_t                  item,
    input  logic                   cmd_full,
    output logic                   cmd_push,
    output cmd_t                   cmd
);

    localparam int CALC_W = LEN_W + 2;
    localparam logic [LEN_W-1:0] TLEN_INIT =
        LEN_W'((TLEN_RESET > TEMPLATE_DEPTH) ? TEMPLATE_DEPTH : TLEN_RESET);
    localparam logic [LEN_W-1:0] BLEN_INIT =
        LEN_W'((BLEN_RESET > BLOCK_DEPTH) ? BLOCK_DEPTH : BLEN_RESET);

    // Effective lengths, already clamped to the store depths.
    logic [LEN_W-1:0] eff_t_reg, eff_b_reg;
    logic [TLEN_W-1:0] tlen_in;
    logic [BLEN_W-1:0] blen_in;

    logic signed [CALC_W-1:0] pa, pb, lo, hi, gap, lim_t, lim_b, lim;
    logic [POS_W-1:0]         offset;

    assign tlen_in = cfg_data[TLEN_W-1:0];
    assign blen_in = cfg_data[BLEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_t_reg <= TLEN_INIT;
            eff_b_reg <= BLEN_INIT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TEMPLATE_LENGTH:
                begin
                    eff_t_reg <= (int'(tlen_in) > TEMPLATE_DEPTH) ?
                                 LEN_W'(TEMPLATE_DEPTH) : LEN_W'(tlen_in);
                end
                REG_BLOCK_LENGTH:
                begin
                    eff_b_reg <= (int'(blen_in) > BLOCK_DEPTH) ?
                                 LEN_W'(BLOCK_DEPTH) : LEN_W'(blen_in);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Run length: phi min(T, B - a); lambda min(T - d, B - hi), d = hi - lo.
    always_comb
    begin
        pa  = CALC_W'(item.position_a);
        pb  = CALC_W'(item.position_b);
        lo  = (pa > pb) ? pb : pa;
        hi  = (pa > pb) ? pa : pb;
        gap = hi - lo;
        if (item.operation == OP_LAMBDA)
        begin
            lim_t  = CALC_W'(eff_t_reg) - gap;
            lim_b  = CALC_W'(eff_b_reg) - hi;
            offset = gap[POS_W-1:0];
        end
        else
        begin
            lim_t  = CALC_W'(eff_t_reg);
            lim_b  = CALC_W'(eff_b_reg) - pa;
            offset = item.position_a;
        end
        lim = (lim_t < lim_b) ? lim_t : lim_b;
    end

    assign cmd_push   = push && !cmd_full;
    assign cmd.op     = item.operation;
    assign cmd.addr   = item.load_address;
    assign cmd.sample = item.sample_value;
    assign cmd.offset = offset;
    assign cmd.len    = (lim[CALC_W-1] || lim == '0) ? '0 : lim[LEN_W-1:0];

endmodule

>>> rtl/pcorr_back.sv
// Back end: template and data sample memories and the multiply-accumulate run.
// Executes each load as it is taken from the queue and runs queries at one product per cycle.
// Depends on pcorr_pkg.
module pcorr_back import pcorr_pkg::*; #(
    parameter int TEMPLATE_DEPTH = DEF_TEMPLATE_DEPTH,
    parameter int BLOCK_DEPTH    = DEF_BLOCK_DEPTH
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_empty,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    input  logic    res_full,
    output logic    res_push,
    output result_t res
);

    localparam int TA_W  = $clog2(TEMPLATE_DEPTH);
    localparam int DA_W  = $clog2(BLOCK_DEPTH);
    localparam int AW2   = (TA_W > DA_W) ? TA_W : DA_W;
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    logic signed [SAMPLE_W-1:0] tmem_reg [TEMPLATE_DEPTH];
    logic signed [SAMPLE_W-1:0] dmem_reg [BLOCK_DEPTH];

    state_t                     state_reg;
    logic [LEN_W-1:0]           cnt_reg, len_reg;
    logic [AW2-1:0]             addr2_reg;
    kind_t                      kind_reg;
    logic                       rd_v_reg, prod_v_reg;
    logic signed [SAMPLE_W-1:0] ta_reg, tb_reg, d_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [SUM_W-1:0]    acc_reg;

    logic                       is_load, start, issue, done, twe, dwe;
    logic signed [SAMPLE_W-1:0] op_b;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [SUM_W:0]      wide;
    logic signed [SUM_W-1:0]    acc_next;

    assign is_load = (cmd.op == OP_LOAD_TEMPLATE) || (cmd.op == OP_LOAD_DATA);
    assign start   = (state_reg == ST_IDLE) && !cmd_empty && (is_load || !res_full);
    assign cmd_pop = start;
    assign twe     = start && (cmd.op == OP_LOAD_TEMPLATE) && (int'(cmd.addr) < TEMPLATE_DEPTH);
    assign dwe     = start && (cmd.op == OP_LOAD_DATA) && (int'(cmd.addr) < BLOCK_DEPTH);
    assign issue   = (state_reg == ST_RUN) && (cnt_reg != len_reg);
    assign done    = (state_reg == ST_RUN) && !issue && !rd_v_reg && !prod_v_reg;

    assign res_push        = done;
    assign res.sum_value   = acc_reg;
    assign res.result_kind = kind_reg;

    // Template memory: one write, two reads (i and i + d for lambda).
    always_ff @(posedge clk)
    begin
        if (twe)
        begin
            tmem_reg[TA_W'(cmd.addr)] <= cmd.sample;
        end
        ta_reg <= tmem_reg[cnt_reg[TA_W-1:0]];
        tb_reg <= tmem_reg[addr2_reg[TA_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (dwe)
        begin
            dmem_reg[DA_W'(cmd.addr)] <= cmd.sample;
        end
        d_reg <= dmem_reg[addr2_reg[DA_W-1:0]];
    end

    always_comb
    begin
        op_b      = (kind_reg == KIND_LAMBDA) ? tb_reg : d_reg;
        prod_next = ta_reg * op_b;
        wide      = {acc_reg[SUM_W-1], acc_reg}
                  + {{(SUM_W + 1 - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        if (wide[SUM_W] != wide[SUM_W-1])
        begin
            acc_next = wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            acc_next = wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            len_reg    <= '0;
            addr2_reg  <= '0;
            kind_reg   <= KIND_PHI;
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
            prod_reg   <= '0;
            acc_reg    <= '0;
        end
        else
        begin
            rd_v_reg   <= issue;
            prod_v_reg <= rd_v_reg;
            if (rd_v_reg)
            begin
                prod_reg <= prod_next;
            end
            if (prod_v_reg)
            begin
                acc_reg <= acc_next;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start && !is_load)
                    begin
                        state_reg <= ST_RUN;
                        cnt_reg   <= '0;
                        len_reg   <= cmd.len;
                        addr2_reg <= AW2'(cmd.offset);
                        kind_reg  <= (cmd.op == OP_LAMBDA) ? KIND_LAMBDA : KIND_PHI;
                        acc_reg   <= '0;
                    end
                end
                ST_RUN:
                begin
                    if (issue)
                    begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        addr2_reg <= addr2_reg + 1'b1;
                    end
                    if (done)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/pulse_template_correlator.sv
// Pulse template correlator. Load the template with operation 0 and the raw
// data block with operation 1, one sample per transfer; loads produce no
// result. A phi query (operation 2) at position_a returns sum(template[i] *
// data[position_a + i]); a lambda query (operation 3) returns the template
// autocorrelation at distance |position_b - position_a|. Both runs are
// truncated by template_length and by the end of the data block, and a run
// of zero length returns 0. The 48-bit Q18.30 sum saturates at every
// addition. A query holds the back end while it takes the command, reads
// the two sample memories at one product per cycle, registers the multiply
// and the accumulate, and hands the sum to the result queue. Items enter a
// two-entry command queue and results leave through a two-entry result
// queue, so input and output stall independently. Write the length
// registers only while the block is idle. Store entries read before they
// were ever written give undefined sums.
// Depends on pcorr_pkg, pcorr_front, pcorr_fifo and pcorr_back.
module pulse_template_correlator import pcorr_pkg::*; #(
    parameter int TEMPLATE_DEPTH = DEF_TEMPLATE_DEPTH,
    parameter int BLOCK_DEPTH    = DEF_BLOCK_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input transfers
    input  logic                   push,
    output logic                   full,
    input  item_t                  item,
    // result transfers
    output logic                   empty,
    input  logic                   pop,
    output result_t                result
);

    cmd_t    front_cmd, back_cmd;
    logic    cmd_push, cmd_full, cmd_empty, cmd_pop;
    result_t back_res;
    logic    res_push, res_full;

    // Front: register writes and classification of each accepted item.
    pcorr_front #(
        .TEMPLATE_DEPTH (TEMPLATE_DEPTH),
        .BLOCK_DEPTH    (BLOCK_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .item      (item),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd       (front_cmd)
    );

    assign full = cmd_full;

    // Command queue decouples intake from the long accumulate runs.
    pcorr_fifo #(
        .T     (cmd_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .data_in  (front_cmd),
        .full     (cmd_full),
        .pop      (cmd_pop),
        .data_out (back_cmd),
        .empty    (cmd_empty)
    );

    // Back: sample memories and multiply-accumulate.
    pcorr_back #(
        .TEMPLATE_DEPTH (TEMPLATE_DEPTH),
        .BLOCK_DEPTH    (BLOCK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (back_cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res)
    );

    // Result queue; the back end starts a query only when a slot is free.
    pcorr_fifo #(
        .T     (result_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_push),
        .data_in  (back_res),
        .full     (res_full),
        .pop      (pop),
        .data_out (result),
        .empty    (empty)
    );

endmodule
